FILE: rtl/core/bt_lpm_pkg.sv
// bt_lpm_pkg: shared types and constants of the binary trie prefix match core
// result codes, mode codes, controller states, command and status structs
// no dependencies
package bt_lpm_pkg;

	// field widths fixed by the stream format
	localparam int ADDR_BITS    = 32;
	localparam int PLEN_W       = 6;
	localparam int IN_HOP_BITS  = 16;
	localparam int OUT_HOP_BITS = 16;

	// s_tdata layout, lowest bit up: ip_address, prefix_length, next_hop
	localparam int IP_LSB    = 0;
	localparam int PLEN_LSB  = IP_LSB + ADDR_BITS;
	localparam int HOP_LSB   = PLEN_LSB + PLEN_W;
	localparam int IN_DATA_W = ((HOP_LSB + IN_HOP_BITS + 7) / 8) * 8;

	// longest prefix and deepest lookup level
	localparam logic [PLEN_W-1:0] PLEN_MAX = PLEN_W'(ADDR_BITS);

	// result codes carried on m_tuser
	typedef enum logic [1:0] {
		ST_INS_OK   = 2'd0,
		ST_INS_FULL = 2'd1,
		ST_HIT      = 2'd2,
		ST_MISS     = 2'd3
	} status_t;

	// item kind carried on s_tuser
	typedef enum logic {
		MODE_INSERT = 1'b0,
		MODE_LOOKUP = 1'b1
	} mode_t;

	// controller states, one-hot
	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_WALK = 2'b10
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic    load;      // capture the input transaction, start at the root
		logic    advance;   // follow the existing child link one level down
		logic    alloc;     // link a fresh node under the current one and step into it
		logic    write_cur; // write the current node back to its store
		logic    set_hop;   // mark the current node with the insert hop
		logic    finish;    // load the result register
		status_t code;      // result code for finish
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_lookup;  // item in flight is a lookup
		logic at_end;     // walk reached prefix length or the last address bit
		logic link_zero;  // child link for the current address bit is empty
		logic pool_full;  // no free node left
		logic hit;        // some node on the lookup path holds a hop
		logic out_free;   // result register can take a new result
	} dp_status_t;

endpackage

FILE: rtl/core/bt_lpm_ctrl.sv
// bt_lpm_ctrl: walk controller of the binary trie prefix match core
// sequences one trie level per cycle and issues datapath commands
// depends on bt_lpm_pkg
module bt_lpm_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  bt_lpm_pkg::dp_status_t st,
	output bt_lpm_pkg::dp_cmd_t    cmd
);
	import bt_lpm_pkg::*;

	state_t state_q;
	state_t state_d;

	// next state and commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_WALK;
				end
			end
			S_WALK: begin
				if (st.is_lookup) begin
					// lookup ends at the last bit or at an empty link
					if (st.at_end || st.link_zero) begin
						if (st.out_free) begin
							cmd.finish = 1'b1;
							cmd.code   = st.hit ? ST_HIT : ST_MISS;
							state_d    = S_IDLE;
						end
					end else begin
						cmd.advance = 1'b1;
					end
				end else begin
					if (st.at_end) begin
						// store the hop at the final node
						if (st.out_free) begin
							cmd.write_cur = 1'b1;
							cmd.set_hop   = 1'b1;
							cmd.finish    = 1'b1;
							cmd.code      = ST_INS_OK;
							state_d       = S_IDLE;
						end
					end else if (!st.link_zero) begin
						cmd.advance = 1'b1;
					end else if (st.pool_full) begin
						// write back the current node so a fresh one is cleared in memory
						if (st.out_free) begin
							cmd.write_cur = 1'b1;
							cmd.finish    = 1'b1;
							cmd.code      = ST_INS_FULL;
							state_d       = S_IDLE;
						end
					end else begin
						cmd.write_cur = 1'b1;
						cmd.alloc     = 1'b1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

endmodule

FILE: rtl/core/bt_lpm_dp.sv
// bt_lpm_dp: datapath of the binary trie prefix match core
// holds the root node, the node memory, the walk registers and the result register
// depends on bt_lpm_pkg
module bt_lpm_dp #(
	parameter int NODE_COUNT = 1024,
	parameter int HOP_BITS   = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic [bt_lpm_pkg::IN_DATA_W-1:0]        in_data,
	input  logic                                   in_mode,
	input  bt_lpm_pkg::dp_cmd_t                    cmd,
	output bt_lpm_pkg::dp_status_t                 st,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [1:0]                             out_status,
	output logic [bt_lpm_pkg::OUT_HOP_BITS-1:0]    out_hop
);
	import bt_lpm_pkg::*;

	localparam int IW = $clog2(NODE_COUNT);
	localparam int CW = $clog2(NODE_COUNT + 1);

	typedef struct packed {
		logic                has;
		logic [HOP_BITS-1:0] hop;
		logic [IW-1:0]       link1;
		logic [IW-1:0]       link0;
	} node_t;

	// walk registers
	logic [ADDR_BITS-1:0] addr_q;
	logic [PLEN_W-1:0]    plen_q;
	logic [PLEN_W-1:0]    depth_q;
	logic [HOP_BITS-1:0]  hop_q;
	mode_t                mode_q;
	logic [IW-1:0]        cur_q;
	node_t                node_q;
	logic                 use_mem_q;
	logic [HOP_BITS-1:0]  best_q;
	logic                 found_q;
	logic [CW-1:0]        used_q;
	node_t                root_q;
	node_t                rd_q;
	node_t                mem_q [NODE_COUNT];

	// result register
	logic                    out_valid_q;
	status_t                 out_status_q;
	logic [OUT_HOP_BITS-1:0] out_hop_q;

	node_t               cur_node;
	node_t               wdata;
	logic [IW-1:0]       nxt;
	logic [IW-1:0]       new_idx;
	logic                bit_sel;
	logic [PLEN_W-1:0]   plen_in;
	logic [31:0]         hop_in_ext;
	logic [HOP_BITS-1:0] sel_hop;
	logic [31:0]         sel_hop_ext;
	logic                out_free;

	// current node comes from memory after an advance, from the holding register after a load or an alloc
	assign cur_node = use_mem_q ? rd_q : node_q;
	assign bit_sel  = addr_q[ADDR_BITS-1];
	assign nxt      = bit_sel ? cur_node.link1 : cur_node.link0;
	assign new_idx  = used_q[IW-1:0];
	assign out_free = !out_valid_q || out_ready;

	// input field decode, prefix length saturated
	assign plen_in    = (in_data[PLEN_LSB +: PLEN_W] > PLEN_MAX) ? PLEN_MAX :
	                    in_data[PLEN_LSB +: PLEN_W];
	assign hop_in_ext = 32'(in_data[HOP_LSB +: IN_HOP_BITS]);

	// lookup hop: deepest node so far including the current one
	assign sel_hop     = cur_node.has ? cur_node.hop : best_q;
	assign sel_hop_ext = 32'(sel_hop);

	// node write data
	always_comb begin
		wdata = cur_node;
		if (cmd.set_hop) begin
			wdata.has = 1'b1;
			wdata.hop = hop_q;
		end
		if (cmd.alloc) begin
			if (bit_sel) begin
				wdata.link1 = new_idx;
			end else begin
				wdata.link0 = new_idx;
			end
		end
	end

	// status to the controller
	always_comb begin
		st.is_lookup = (mode_q == MODE_LOOKUP);
		st.at_end    = (mode_q == MODE_LOOKUP) ? (depth_q == PLEN_MAX) : (depth_q == plen_q);
		st.link_zero = (nxt == '0);
		st.pool_full = (used_q >= CW'(NODE_COUNT));
		st.hit       = found_q || cur_node.has;
		st.out_free  = out_free;
	end

	// control state: root node, pool count, node source, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q      <= '0;
			used_q      <= CW'(1);
			use_mem_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.write_cur && (cur_q == '0)) begin
				root_q <= wdata;
			end
			if (cmd.alloc) begin
				used_q <= used_q + CW'(1);
			end
			if (cmd.load || cmd.alloc) begin
				use_mem_q <= 1'b0;
			end else if (cmd.advance) begin
				use_mem_q <= 1'b1;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// walk payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			addr_q  <= in_data[IP_LSB +: ADDR_BITS];
			plen_q  <= plen_in;
			hop_q   <= hop_in_ext[HOP_BITS-1:0];
			mode_q  <= mode_t'(in_mode);
			cur_q   <= '0;
			node_q  <= root_q;
			depth_q <= '0;
			found_q <= 1'b0;
			best_q  <= '0;
		end else if (cmd.advance || cmd.alloc) begin
			addr_q  <= addr_q << 1;
			depth_q <= depth_q + PLEN_W'(1);
			if (cmd.alloc) begin
				cur_q  <= new_idx;
				node_q <= '0;
			end else begin
				cur_q <= nxt;
				if ((mode_q == MODE_LOOKUP) && cur_node.has) begin
					best_q  <= cur_node.hop;
					found_q <= 1'b1;
				end
			end
		end
		if (cmd.finish) begin
			out_status_q <= cmd.code;
			out_hop_q    <= (cmd.code == ST_HIT) ? sel_hop_ext[OUT_HOP_BITS-1:0] : '0;
		end
	end

	// node memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (cmd.write_cur && (cur_q != '0)) begin
			mem_q[cur_q] <= wdata;
		end
		if (cmd.advance) begin
			rd_q <= mem_q[nxt];
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_hop    = out_hop_q;

endmodule

FILE: rtl/core/binary_trie_longest_prefix_match_core.sv
// binary_trie_longest_prefix_match_core: top level of the IPv4 prefix match engine
// joins the walk controller and the node datapath
// depends on bt_lpm_pkg, bt_lpm_ctrl, bt_lpm_dp
//
// Usage
//   s_* channel takes one route insert or address lookup per transaction;
//   s_tuser is 0 for insert, 1 for lookup. m_* channel returns one result per
//   item, with the result code on m_tuser and the matched hop on m_tdata.
//   The trie is walked one level per clock: node 0 sits in flip-flops and the
//   other nodes sit in a single-port-read, single-port-write node memory whose
//   registered read sets the pace of one level per cycle.
//   Walk: a lookup steps down to the deepest node it reaches, at depth 0..32;
//   an insert steps down to its saturated prefix length, at most 32. The input
//   reopens in the cycle in which the result appears on m_tvalid, so an item
//   is taken only once the previous one is through its walk.
//   Reset: the root is cleared and one node is counted as used; no clearing
//   pass runs, allocated nodes are cleared when they are handed out.
//   Stall: a held result stays in m_tdata/m_tuser; the next item is still
//   accepted and walks, and it waits at its last level until m_tready frees
//   the output register.
module binary_trie_longest_prefix_match_core #(
	parameter int NODE_COUNT = 1024,
	parameter int HOP_BITS   = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [bt_lpm_pkg::IN_DATA_W-1:0]     s_tdata,  // ip_address, prefix_length, next_hop
	input  logic                                s_tuser,  // mode
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [bt_lpm_pkg::OUT_HOP_BITS-1:0]  m_tdata,  // matched_hop
	output logic [1:0]                          m_tuser   // status
);
	import bt_lpm_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t st;

	// walk controller
	bt_lpm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	// node store and walk datapath
	bt_lpm_dp #(
		.NODE_COUNT (NODE_COUNT),
		.HOP_BITS   (HOP_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_data    (s_tdata),
		.in_mode    (s_tuser),
		.cmd        (cmd),
		.st         (st),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (m_tuser),
		.out_hop    (m_tdata)
	);

	// a node is never handed out of an exhausted pool
	a_alloc_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc |-> !st.pool_full)
		else $error("node allocated with the pool exhausted");

	// a result never overwrites one that is still held
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !cmd.finish)
		else $error("result register overwritten while stalled");

	// the walk only follows links that exist
	a_advance_link: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.advance |-> !st.link_zero)
		else $error("walk followed an empty link");

	// an accepted item keeps the input closed in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input reopened while an item is in flight");

endmodule

FILE: tb/bt_lpm_tb_pkg.sv
// bt_lpm_tb_pkg: route trie predictor and result scoreboard for the prefix match testbench
// keeps its own copy of the node pool and a queue of expected result transactions
// depends on bt_lpm_pkg
package bt_lpm_tb_pkg;

	import bt_lpm_pkg::*;

	// node pool size of the block under test
	localparam int TRIE_NODES = 1024;

	// one expected result transaction
	typedef struct {
		status_t                 status;
		logic [OUT_HOP_BITS-1:0] hop;
	} route_reply_t;

	class lpm_scoreboard;
		bit                       hop_valid [TRIE_NODES];
		logic [IN_HOP_BITS-1:0]   hop_val [TRIE_NODES];
		int unsigned              child [TRIE_NODES][2];
		int unsigned              nodes_used;
		route_reply_t             expected_replies [$];
		int                       errors;
		int                       n_ins_ok;
		int                       n_ins_full;
		int                       n_hit;
		int                       n_miss;

		function new();
			for (int i = 0; i < TRIE_NODES; i++)
				clear_node(i);
			nodes_used = 1;
			errors     = 0;
			n_ins_ok   = 0;
			n_ins_full = 0;
			n_hit      = 0;
			n_miss     = 0;
		endfunction

		function void clear_node(int unsigned idx);
			hop_valid[idx] = 1'b0;
			hop_val[idx]   = '0;
			child[idx][0]  = 0;
			child[idx][1]  = 0;
		endfunction

		// walk or grow the path of the prefix, then store the hop at its end
		function status_t add_route(logic [ADDR_BITS-1:0] ip, logic [PLEN_W-1:0] plen,
				logic [IN_HOP_BITS-1:0] hop);
			int unsigned depth;
			int unsigned cur;
			int unsigned nxt;
			int unsigned bits;
			bits = (plen > ADDR_BITS) ? ADDR_BITS : plen;
			cur  = 0;
			for (depth = 0; depth < bits; depth++) begin
				nxt = child[cur][ip[ADDR_BITS-1-depth]];
				if (nxt == 0) begin
					// pool exhausted: nodes taken so far stay, hop is dropped
					if (nodes_used >= TRIE_NODES)
						return ST_INS_FULL;
					nxt = nodes_used;
					nodes_used++;
					clear_node(nxt);
					child[cur][ip[ADDR_BITS-1-depth]] = nxt;
				end
				cur = nxt;
			end
			hop_valid[cur] = 1'b1;
			hop_val[cur]   = hop;
			return ST_INS_OK;
		endfunction

		// deepest hop on the path of the address, root and /32 level included
		function status_t match_route(logic [ADDR_BITS-1:0] ip,
				output logic [OUT_HOP_BITS-1:0] best);
			int unsigned depth;
			int unsigned cur;
			int unsigned nxt;
			bit          found;
			cur   = 0;
			found = 1'b0;
			best  = '0;
			for (depth = 0; depth <= ADDR_BITS; depth++) begin
				if (hop_valid[cur]) begin
					found = 1'b1;
					best  = hop_val[cur];
				end
				if (depth == ADDR_BITS)
					break;
				nxt = child[cur][ip[ADDR_BITS-1-depth]];
				if (nxt == 0)
					break;
				cur = nxt;
			end
			return found ? ST_HIT : ST_MISS;
		endfunction

		// accepted input transaction: update the trie and queue its result
		function void note_request(mode_t mode, logic [ADDR_BITS-1:0] ip,
				logic [PLEN_W-1:0] plen, logic [IN_HOP_BITS-1:0] hop);
			route_reply_t r;
			r.hop = '0;
			if (mode == MODE_INSERT)
				r.status = add_route(ip, plen, hop);
			else
				r.status = match_route(ip, r.hop);
			case (r.status)
				ST_INS_OK:   n_ins_ok++;
				ST_INS_FULL: n_ins_full++;
				ST_HIT:      n_hit++;
				default:     n_miss++;
			endcase
			expected_replies.push_back(r);
		endfunction

		function int pending();
			return expected_replies.size();
		endfunction

		// accepted result transaction: compare with the oldest expectation
		function void check_reply(logic [1:0] status, logic [OUT_HOP_BITS-1:0] hop,
				longint unsigned stamp);
			route_reply_t want;
			if (expected_replies.size() == 0) begin
				errors++;
				$display("%0t ns ERROR: unexpected result, status %0d hop %h", stamp,
					status, hop);
				return;
			end
			want = expected_replies.pop_front();
			if (status !== want.status) begin
				errors++;
				$display("%0t ns ERROR: status expected %s (%0d) actual %0d", stamp,
					want.status.name(), want.status, status);
			end
			if (hop !== want.hop) begin
				errors++;
				$display("%0t ns ERROR: matched_hop expected %h actual %h", stamp,
					want.hop, hop);
			end
		endfunction
	endclass

endpackage

FILE: tb/tb_binary_trie_longest_prefix_match_core.sv
// tb_binary_trie_longest_prefix_match_core: stream testbench of the prefix match core
// directed route cases, then random inserts and lookups with idling and back pressure
// depends on bt_lpm_pkg, bt_lpm_tb_pkg, binary_trie_longest_prefix_match_core
module tb_binary_trie_longest_prefix_match_core;

	timeunit 1ns;
	timeprecision 1ps;

	import bt_lpm_pkg::*;
	import bt_lpm_tb_pkg::*;

	localparam int RANDOM_ITEMS = 1300;
	localparam int STALL_LIMIT  = 4000;  // cycles with no transaction on either side
	localparam int HOLD_CYCLES  = 500;   // long receiver hold-off
	localparam int SETTLE       = 40;    // longer than the deepest walk

	logic                          clk;
	logic                          arst_n;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [IN_DATA_W-1:0]          s_tdata;
	logic                          s_tuser;
	logic                          m_tvalid;
	logic                          m_tready;
	logic [OUT_HOP_BITS-1:0]       m_tdata;
	logic [1:0]                    m_tuser;

	lpm_scoreboard                 sb;
	bit                            idle_on;
	bit                            hold_req;
	int unsigned                   quiet_cycles;
	logic [ADDR_BITS-1:0]          base_net [8];
	logic [ADDR_BITS-1:0]          seen_routes [$];

	binary_trie_longest_prefix_match_core #(
		.NODE_COUNT(TRIE_NODES),
		.HOP_BITS  (IN_HOP_BITS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	// clock
	always #2 clk = ~clk;

	// gap length: mostly none or short, now and then long
	function automatic int unsigned idle_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 20);
		else
			return $urandom_range(40, 120);
	endfunction

	// offer one transaction and wait for its acceptance
	task automatic send_item(mode_t mode, logic [ADDR_BITS-1:0] ip,
			logic [PLEN_W-1:0] plen, logic [IN_HOP_BITS-1:0] hop);
		int unsigned gap;
		gap = idle_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= IN_DATA_W'({hop, plen, ip});
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_request(mode, ip, plen, hop);
	endtask

	// sender pause until every result is back, then let the walk settle
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// random route or lookup, mostly around a few shared networks
	task automatic send_random();
		int unsigned          r;
		mode_t                mode;
		logic [ADDR_BITS-1:0] ip;
		logic [PLEN_W-1:0]    plen;
		logic [IN_HOP_BITS-1:0] hop;
		hop  = IN_HOP_BITS'($urandom_range(0, 65535));
		plen = PLEN_W'($urandom_range(0, 63));
		mode = ($urandom_range(0, 99) < 45) ? MODE_INSERT : MODE_LOOKUP;
		r    = $urandom_range(0, 99);
		if (mode == MODE_INSERT) begin
			if (r < 60)
				ip = base_net[$urandom_range(0, 7)] ^ ($urandom >> $urandom_range(8, 31));
			else
				ip = $urandom;
			r = $urandom_range(0, 99);
			if (r < 15)
				plen = PLEN_W'($urandom_range(0, 7));
			else if (r < 55)
				plen = PLEN_W'($urandom_range(8, 24));
			else if (r < 90)
				plen = PLEN_W'($urandom_range(25, 32));
			else
				plen = PLEN_W'($urandom_range(33, 63));
			seen_routes.push_back(ip);
			if (seen_routes.size() > 256)
				void'(seen_routes.pop_front());
		end else begin
			if (r < 50 && seen_routes.size() != 0)
				ip = seen_routes[$urandom_range(0, seen_routes.size() - 1)] ^
					($urandom >> $urandom_range(20, 32));
			else if (r < 70)
				ip = base_net[$urandom_range(0, 7)] ^ ($urandom >> $urandom_range(4, 31));
			else
				ip = $urandom;
		end
		send_item(mode, ip, plen, hop);
	endtask

	// receiver: check results, drive ready with random stalls and the long hold-off
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				sb.check_reply(m_tuser, m_tdata, $time);
			if (hold_req) begin
				hold_req   = 1'b0;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready   <= 1'b1;
				stall_left = idle_gap();
			end
		end
	end

	// watchdog on cycles with no transaction
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t ns timeout after %0d idle cycles", $time, quiet_cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// stimulus
	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = MODE_INSERT;
		m_tready     = 1'b0;
		idle_on      = 1'b0;
		hold_req     = 1'b0;
		quiet_cycles = 0;
		sb           = new();
		for (int i = 0; i < 8; i++)
			base_net[i] = $urandom;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty trie, default route, /32 extremes, masking, overwrite, saturation
		send_item(MODE_LOOKUP, 32'h0A00_0001, 6'd0,  16'h0000);
		send_item(MODE_INSERT, 32'h0000_0000, 6'd0,  16'h1234);
		send_item(MODE_LOOKUP, 32'hC0A8_0101, 6'd0,  16'h0000);
		send_item(MODE_INSERT, 32'hFFFF_FFFF, 6'd32, 16'hFFFF);
		send_item(MODE_LOOKUP, 32'hFFFF_FFFF, 6'd0,  16'h0000);
		send_item(MODE_LOOKUP, 32'hFFFF_FFFE, 6'd0,  16'h0000);
		send_item(MODE_INSERT, 32'h0000_0000, 6'd32, 16'h0000);
		send_item(MODE_LOOKUP, 32'h0000_0000, 6'd0,  16'h0000);
		send_item(MODE_INSERT, 32'h0AFF_FFFF, 6'd8,  16'h0A0A);
		send_item(MODE_LOOKUP, 32'h0A12_3456, 6'd0,  16'h0000);
		send_item(MODE_INSERT, 32'h0A01_0000, 6'd16, 16'h0B0B);
		send_item(MODE_LOOKUP, 32'h0A01_FFFF, 6'd0,  16'h0000);
		send_item(MODE_LOOKUP, 32'h0A02_0304, 6'd0,  16'h0000);
		send_item(MODE_INSERT, 32'h0A01_0000, 6'd16, 16'h0C0C);
		send_item(MODE_LOOKUP, 32'h0A01_0203, 6'd0,  16'h0000);
		send_item(MODE_INSERT, 32'hAC10_0000, 6'd63, 16'h5555);
		send_item(MODE_LOOKUP, 32'hAC10_0000, 6'd0,  16'h0000);
		send_item(MODE_LOOKUP, 32'hAC10_0001, 6'd0,  16'h0000);
		send_item(MODE_INSERT, 32'h8000_0000, 6'd1,  16'h8001);
		send_item(MODE_LOOKUP, 32'hFFFF_FFFE, 6'd0,  16'h0000);
		send_item(MODE_INSERT, 32'h1234_5678, 6'd33, 16'hAAAA);
		send_item(MODE_LOOKUP, 32'h1234_5678, 6'd63, 16'hFFFF);
		send_item(MODE_INSERT, 32'h1234_5678, 6'd0,  16'h0001);
		send_item(MODE_LOOKUP, 32'h5555_5555, 6'd0,  16'h0000);
		drain_results();

		// random: idling on except for one calm stretch, one long hold-off, one pause
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			idle_on = !(i >= 800 && i < 950);
			if (i == 300)
				hold_req = 1'b1;
			if (i == 650)
				drain_results();
			send_random();
		end

		// wait for the last results and the block to settle
		drain_results();
		$display("Ran %0d transactions: %0d inserts stored, %0d refused on a full pool",
			sb.n_ins_ok + sb.n_ins_full + sb.n_hit + sb.n_miss, sb.n_ins_ok, sb.n_ins_full);
		$display("Lookups: %0d hits, %0d misses; trie nodes in use: %0d of %0d",
			sb.n_hit, sb.n_miss, sb.nodes_used, TRIE_NODES);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
